/* rtl/tgc_pkg.sv */
// ----------------------------------------------------------------------------
// tgc_pkg: shared types and constants of the touch gesture classifier
// Event kinds, action codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

   localparam int COORD_BITS_DEFAULT = 10;

   // Configuration register width and index width.
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_SLOP  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_MIN = 1'd1;

   localparam logic [CFG_W-1:0] TAP_SLOP_RESET  = 10'd12;
   localparam logic [CFG_W-1:0] SWIPE_MIN_RESET = 10'd48;

   // Dominance ratio: the dominant axis times DOM_NUM must reach the other
   // axis times DOM_DEN.
   localparam int DOM_NUM = 4;
   localparam int DOM_DEN = 5;

   localparam int KIND_W   = 3;
   localparam int ACTION_W = 3;
   localparam int FINGER_W = 3;

   localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MOVE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LONG    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOST    = 3'd4;

   localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RESET_PEAK = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PAGE_ONE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_PAGE_ZERO  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_THEME_NEXT = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_THEME_PREV = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_BRIGHT     = 3'd6;

   typedef struct packed {
      logic [CFG_W-1:0] tap_slop;
      logic [CFG_W-1:0] swipe_min;
   } tgc_cfg_type;

endpackage

`default_nettype wire

/* rtl/tgc_csr.sv */
// ----------------------------------------------------------------------------
// tgc_csr: configuration registers
// Holds the tap slop and swipe threshold, written through the csr port.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [tgc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tgc_pkg::CFG_W-1:0]      csr_wdata,
   output      tgc_pkg::tgc_cfg_type           cfg
);

   tgc_pkg::tgc_cfg_type cfg_ff;
   tgc_pkg::tgc_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tgc_pkg::CSR_TAP_SLOP:  cfg_in.tap_slop  = csr_wdata;
            tgc_pkg::CSR_SWIPE_MIN: cfg_in.swipe_min = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_slop  <= tgc_pkg::TAP_SLOP_RESET;
         cfg_ff.swipe_min <= tgc_pkg::SWIPE_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tgc_in_reg.sv */
// ----------------------------------------------------------------------------
// tgc_in_reg: input register
// Captures one touch event per cycle while req_stall is low, and holds it until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_in_reg #(
   parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [tgc_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [COORD_BITS-1:0]         req_pos_x,
   input  wire logic [COORD_BITS-1:0]         req_pos_y,
   input  wire logic [tgc_pkg::FINGER_W-1:0]  req_finger_count,
   input  wire logic                          req_media_busy,
   input  wire logic                          advance,
   output      logic                          ev_valid,
   output      logic [tgc_pkg::KIND_W-1:0]    ev_kind,
   output      logic [COORD_BITS-1:0]         ev_x,
   output      logic [COORD_BITS-1:0]         ev_y,
   output      logic                          ev_multi,
   output      logic                          ev_media
);

   logic                        valid_ff, valid_in;
   logic [tgc_pkg::KIND_W-1:0]  kind_ff;
   logic [COORD_BITS-1:0]       x_ff, y_ff;
   logic                        multi_ff, media_ff;
   logic                        take;

   // The held event leaves in the same cycle that a new one arrives.
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= req_kind;
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         multi_ff <= (req_finger_count >= tgc_pkg::FINGER_W'(2));
         media_ff <= req_media_busy;
      end
   end

   assign ev_valid = valid_ff;
   assign ev_kind  = kind_ff;
   assign ev_x     = x_ff;
   assign ev_y     = y_ff;
   assign ev_multi = multi_ff;
   assign ev_media = media_ff;

endmodule

`default_nettype wire

/* rtl/tgc_engine.sv */
// ----------------------------------------------------------------------------
// tgc_engine: gesture state and classification
// Tracks the press, classifies releases and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_engine #(
   parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tgc_pkg::tgc_cfg_type          cfg,
   input  wire logic                          ev_valid,
   input  wire logic [tgc_pkg::KIND_W-1:0]    ev_kind,
   input  wire logic [COORD_BITS-1:0]         ev_x,
   input  wire logic [COORD_BITS-1:0]         ev_y,
   input  wire logic                          ev_multi,
   input  wire logic                          ev_media,
   output      logic                          advance,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [tgc_pkg::ACTION_W-1:0]  rsp_action,
   output      logic                          rsp_active_page_out
);

   localparam int DW    = COORD_BITS + 1;
   localparam int CMP_W = (DW > tgc_pkg::CFG_W) ? DW : tgc_pkg::CFG_W;
   localparam int PW    = CMP_W + 3;

   // Gesture state.
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic [COORD_BITS-1:0] start_y_ff, start_y_in;
   logic [DW-1:0]         peak_dx_ff, peak_dx_in;
   logic [DW-1:0]         peak_dy_ff, peak_dy_in;
   logic                  pressing_ff, pressing_in;
   logic                  hold_done_ff, hold_done_in;
   logic                  two_seen_ff, two_seen_in;
   logic                  page_ff, page_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tgc_pkg::ACTION_W-1:0]  action_ff, action_in;
   logic                          page_out_ff;

   logic                  fire;
   logic [DW-1:0]         dx, dy, mag_dx, mag_dy, mag_pdx, mag_pdy;
   logic                  track_on;
   logic [DW-1:0]         pdx_t, pdy_t, ax, ay;
   logic [CMP_W-1:0]      ax_c, ay_c, slop_c, smin_c;
   logic [PW-1:0]         ax_num, ay_num, ax_den, ay_den;
   logic                  is_tap, is_hswipe, is_vswipe, suppressed;
   logic                  pdx_neg, pdx_pos;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = ev_valid && advance;

   // Excursion from the start point and its magnitude.
   assign dx      = {1'b0, ev_x} - {1'b0, start_x_ff};
   assign dy      = {1'b0, ev_y} - {1'b0, start_y_ff};
   assign mag_dx  = dx[DW-1] ? (~dx + 1'b1) : dx;
   assign mag_dy  = dy[DW-1] ? (~dy + 1'b1) : dy;
   assign mag_pdx = peak_dx_ff[DW-1] ? (~peak_dx_ff + 1'b1) : peak_dx_ff;
   assign mag_pdy = peak_dy_ff[DW-1] ? (~peak_dy_ff + 1'b1) : peak_dy_ff;

   always_comb begin
      unique case (ev_kind)
         tgc_pkg::KIND_MOVE:    track_on = pressing_ff;
         tgc_pkg::KIND_LONG:    track_on = pressing_ff && !hold_done_ff && !ev_multi;
         tgc_pkg::KIND_RELEASE: track_on = pressing_ff;
         default:               track_on = 1'b0;
      endcase
   end

   assign pdx_t = (track_on && (mag_dx > mag_pdx)) ? dx : peak_dx_ff;
   assign pdy_t = (track_on && (mag_dy > mag_pdy)) ? dy : peak_dy_ff;
   assign ax    = pdx_t[DW-1] ? (~pdx_t + 1'b1) : pdx_t;
   assign ay    = pdy_t[DW-1] ? (~pdy_t + 1'b1) : pdy_t;

   assign ax_c   = CMP_W'(ax);
   assign ay_c   = CMP_W'(ay);
   assign slop_c = CMP_W'(cfg.tap_slop);
   assign smin_c = CMP_W'(cfg.swipe_min);

   // Scale by 4 is a shift, scale by 5 is a shift plus the value.
   assign ax_num = {1'b0, ax_c, 2'b00};
   assign ay_num = {1'b0, ay_c, 2'b00};
   assign ax_den = {1'b0, ax_c, 2'b00} + PW'(ax_c);
   assign ay_den = {1'b0, ay_c, 2'b00} + PW'(ay_c);

   assign pdx_neg = pdx_t[DW-1];
   assign pdx_pos = !pdx_t[DW-1] && (pdx_t != '0);

   assign is_tap     = (ax_c < slop_c) && (ay_c < slop_c);
   assign is_hswipe  = (ax_c >= smin_c) && (ax_num >= ay_den);
   assign is_vswipe  = !page_ff && (ay_c >= smin_c) && (ay_num >= ax_den);
   assign suppressed = hold_done_ff || ev_media || two_seen_in;

   always_comb begin
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      peak_dx_in   = pdx_t;
      peak_dy_in   = pdy_t;
      pressing_in  = pressing_ff;
      hold_done_in = hold_done_ff;
      page_in      = page_ff;
      action_in    = tgc_pkg::ACT_NONE;

      two_seen_in = (ev_kind == tgc_pkg::KIND_PRESS) ? 1'b0 : two_seen_ff;
      if ((ev_kind <= tgc_pkg::KIND_LOST) && ev_multi) begin
         two_seen_in = 1'b1;
      end

      unique case (ev_kind)
         tgc_pkg::KIND_PRESS: begin
            start_x_in   = ev_x;
            start_y_in   = ev_y;
            peak_dx_in   = '0;
            peak_dy_in   = '0;
            pressing_in  = 1'b1;
            hold_done_in = 1'b0;
         end
         tgc_pkg::KIND_MOVE: ;
         tgc_pkg::KIND_LONG: begin
            if (track_on) begin
               hold_done_in = 1'b1;
               action_in    = tgc_pkg::ACT_BRIGHT;
            end
         end
         tgc_pkg::KIND_RELEASE: begin
            if (pressing_ff) begin
               pressing_in  = 1'b0;
               hold_done_in = 1'b0;
               // A horizontal swipe candidate is never retested as vertical.
               if (!suppressed) begin
                  priority if (is_tap) begin
                     if (!page_ff) action_in = tgc_pkg::ACT_RESET_PEAK;
                  end else if (is_hswipe) begin
                     if (!page_ff && pdx_neg) begin
                        page_in   = 1'b1;
                        action_in = tgc_pkg::ACT_PAGE_ONE;
                     end else if (page_ff && pdx_pos) begin
                        page_in   = 1'b0;
                        action_in = tgc_pkg::ACT_PAGE_ZERO;
                     end
                  end else if (is_vswipe) begin
                     action_in = pdy_t[DW-1] ? tgc_pkg::ACT_THEME_NEXT
                                             : tgc_pkg::ACT_THEME_PREV;
                  end else begin
                     action_in = tgc_pkg::ACT_NONE;
                  end
               end
            end
         end
         tgc_pkg::KIND_LOST: begin
            if (pressing_ff) begin
               pressing_in  = 1'b0;
               hold_done_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         peak_dx_ff   <= '0;
         peak_dy_ff   <= '0;
         pressing_ff  <= 1'b0;
         hold_done_ff <= 1'b0;
         two_seen_ff  <= 1'b0;
         page_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            start_x_ff   <= start_x_in;
            start_y_ff   <= start_y_in;
            peak_dx_ff   <= peak_dx_in;
            peak_dy_ff   <= peak_dy_in;
            pressing_ff  <= pressing_in;
            hold_done_ff <= hold_done_in;
            two_seen_ff  <= two_seen_in;
            page_ff      <= page_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         action_ff   <= action_in;
         page_out_ff <= page_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = action_ff;
   assign rsp_active_page_out = page_out_ff;

endmodule

`default_nettype wire

/* rtl/touch_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// touch_gesture_classifier: tap, swipe and hold classifier for touch events
// Turns single-pointer touch events into page, theme and brightness actions.
// ----------------------------------------------------------------------------
// Every accepted event yields exactly one result transaction carrying an
// action code and the page that is active after the event. The block takes one
// event per clock cycle while a held result does not stall it; an accepted
// event passes through the input register and then the result register,
// with the gesture state updated in the same cycle that the result register
// loads. A held result stalls the input side only when the input register is
// also full. Configuration writes are accepted in every cycle and should be
// issued while no event is in flight.
`default_nettype none

module touch_gesture_classifier #(
   parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [tgc_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [COORD_BITS-1:0]         req_pos_x,
   input  wire logic [COORD_BITS-1:0]         req_pos_y,
   input  wire logic [tgc_pkg::FINGER_W-1:0]  req_finger_count,
   input  wire logic                          req_media_busy,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [tgc_pkg::ACTION_W-1:0]  rsp_action,
   output      logic                          rsp_active_page_out,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [tgc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tgc_pkg::CFG_W-1:0]     csr_wdata
);

   tgc_pkg::tgc_cfg_type        cfg;
   logic                        advance;
   logic                        ev_valid;
   logic [tgc_pkg::KIND_W-1:0]  ev_kind;
   logic [COORD_BITS-1:0]       ev_x, ev_y;
   logic                        ev_multi, ev_media;

   tgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tgc_in_reg #(.COORD_BITS(COORD_BITS)) u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_finger_count (req_finger_count),
      .req_media_busy   (req_media_busy),
      .advance          (advance),
      .ev_valid         (ev_valid),
      .ev_kind          (ev_kind),
      .ev_x             (ev_x),
      .ev_y             (ev_y),
      .ev_multi         (ev_multi),
      .ev_media         (ev_media)
   );

   tgc_engine #(.COORD_BITS(COORD_BITS)) u_engine (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .ev_valid            (ev_valid),
      .ev_kind             (ev_kind),
      .ev_x                (ev_x),
      .ev_y                (ev_y),
      .ev_multi            (ev_multi),
      .ev_media            (ev_media),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_active_page_out (rsp_active_page_out)
   );

endmodule

`default_nettype wire

/* rtl/tgc_checker.sv */
// ----------------------------------------------------------------------------
// tgc_checker: port-level checks for the touch gesture classifier
// Watches the result channel for consistency between actions and pages.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [tgc_pkg::ACTION_W-1:0]  rsp_action,
   input wire logic                          rsp_active_page_out
);

   // No result transaction is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result stays offered and unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action)
                                 && $stable(rsp_active_page_out))
      else $error("stalled result changed");

   // A switch to page one reports page one as active.
   a_page_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == tgc_pkg::ACT_PAGE_ONE) |-> rsp_active_page_out)
      else $error("page one action with page zero active");

   // A switch to page zero, and a peak reset, leave page zero active.
   a_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_action == tgc_pkg::ACT_PAGE_ZERO)
                    || (rsp_action == tgc_pkg::ACT_RESET_PEAK))
      |-> !rsp_active_page_out)
      else $error("page zero action with page one active");

   // Theme steps happen only on the gauge page.
   a_theme_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_action == tgc_pkg::ACT_THEME_NEXT)
                    || (rsp_action == tgc_pkg::ACT_THEME_PREV))
      |-> !rsp_active_page_out)
      else $error("theme action on the second page");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_action          (rsp_action),
   .rsp_active_page_out (rsp_active_page_out)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for touch_gesture_classifier
// Drives touch event transactions with random gaps and result stalls. A
// scoreboard predicts the action and the active page of every event. The run
// steps through several threshold settings, including the extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int CB       = tgc_pkg::COORD_BITS_DEFAULT;
   localparam int COORD_MAX = (1 << CB) - 1;

   // Event kinds that the block does not define.
   localparam logic [tgc_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [tgc_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [tgc_pkg::ACTION_W-1:0] action;
      logic                         page;
   } gesture_result_type;

   class gesture_scoreboard;
      logic [tgc_pkg::CFG_W-1:0] tap_slop;
      logic [tgc_pkg::CFG_W-1:0] swipe_min;
      logic [CB-1:0]     start_x;
      logic [CB-1:0]     start_y;
      logic signed [CB:0] peak_dx;
      logic signed [CB:0] peak_dy;
      logic              pressing;
      logic              hold_done;
      logic              two_finger_seen;
      logic              active_page;
      gesture_result_type pending_results[$];
      int                mismatches;

      function new();
         tap_slop        = tgc_pkg::TAP_SLOP_RESET;
         swipe_min       = tgc_pkg::SWIPE_MIN_RESET;
         start_x         = '0;
         start_y         = '0;
         peak_dx         = '0;
         peak_dy         = '0;
         pressing        = 1'b0;
         hold_done       = 1'b0;
         two_finger_seen = 1'b0;
         active_page     = 1'b0;
         mismatches      = 0;
      endfunction

      function void write_reg(logic [tgc_pkg::CSR_IDX_W-1:0] index,
                              logic [tgc_pkg::CFG_W-1:0] data);
         if (index == tgc_pkg::CSR_TAP_SLOP)
            tap_slop = data;
         else if (index == tgc_pkg::CSR_SWIPE_MIN)
            swipe_min = data;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      // Keeps the signed excursion with the largest magnitude on each axis.
      function void follow(logic [CB-1:0] x, logic [CB-1:0] y);
         int dx;
         int dy;
         dx = int'(x) - int'(start_x);
         dy = int'(y) - int'(start_y);
         if (magnitude(dx) > magnitude(int'(peak_dx))) peak_dx = dx[CB:0];
         if (magnitude(dy) > magnitude(int'(peak_dy))) peak_dy = dy[CB:0];
      endfunction

      function logic [tgc_pkg::ACTION_W-1:0] classify_release(logic media);
         int ax;
         int ay;
         ax = magnitude(int'(peak_dx));
         ay = magnitude(int'(peak_dy));
         if (hold_done || media || two_finger_seen)
            return tgc_pkg::ACT_NONE;
         if (ax < int'(tap_slop) && ay < int'(tap_slop))
            return (active_page == 1'b0) ? tgc_pkg::ACT_RESET_PEAK : tgc_pkg::ACT_NONE;
         // A horizontal swipe is never tested as a vertical one as well.
         if (ax >= int'(swipe_min) && ax * tgc_pkg::DOM_NUM >= ay * tgc_pkg::DOM_DEN) begin
            if (active_page == 1'b0 && peak_dx < 0) begin
               active_page = 1'b1;
               return tgc_pkg::ACT_PAGE_ONE;
            end
            if (active_page == 1'b1 && peak_dx > 0) begin
               active_page = 1'b0;
               return tgc_pkg::ACT_PAGE_ZERO;
            end
            return tgc_pkg::ACT_NONE;
         end
         if (active_page == 1'b0 && ay >= int'(swipe_min)
             && ay * tgc_pkg::DOM_NUM >= ax * tgc_pkg::DOM_DEN)
            return (peak_dy < 0) ? tgc_pkg::ACT_THEME_NEXT : tgc_pkg::ACT_THEME_PREV;
         return tgc_pkg::ACT_NONE;
      endfunction

      function void note_event(logic [tgc_pkg::KIND_W-1:0] kind, logic [CB-1:0] x,
                               logic [CB-1:0] y, logic [tgc_pkg::FINGER_W-1:0] fingers,
                               logic media);
         logic               multi;
         gesture_result_type res;
         multi      = (fingers >= 2);
         res.action = tgc_pkg::ACT_NONE;
         if (kind == tgc_pkg::KIND_PRESS) begin
            start_x         = x;
            start_y         = y;
            peak_dx         = '0;
            peak_dy         = '0;
            pressing        = 1'b1;
            hold_done       = 1'b0;
            two_finger_seen = 1'b0;
         end
         if (kind <= tgc_pkg::KIND_LOST && multi) two_finger_seen = 1'b1;
         case (kind)
            tgc_pkg::KIND_MOVE: begin
               if (pressing) follow(x, y);
            end
            tgc_pkg::KIND_LONG: begin
               if (pressing && !hold_done && !multi) begin
                  follow(x, y);
                  hold_done  = 1'b1;
                  res.action = tgc_pkg::ACT_BRIGHT;
               end
            end
            tgc_pkg::KIND_RELEASE: begin
               if (pressing) begin
                  follow(x, y);
                  res.action = classify_release(media);
                  pressing   = 1'b0;
                  hold_done  = 1'b0;
               end
            end
            tgc_pkg::KIND_LOST: begin
               if (pressing) begin
                  pressing  = 1'b0;
                  hold_done = 1'b0;
               end
            end
            default: ;
         endcase
         res.page = active_page;
         pending_results.push_back(res);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic [tgc_pkg::ACTION_W-1:0] action, logic page);
         gesture_result_type want;
         if (pending_results.size() == 0) begin
            flag($sformatf("unexpected result transaction: action %0d page %0d", action, page));
            return;
         end
         want = pending_results.pop_front();
         if (action !== want.action)
            flag($sformatf("action mismatch: expected %0d, got %0d", want.action, action));
         if (page !== want.page)
            flag($sformatf("active page mismatch: expected %0d, got %0d", want.page, page));
      endfunction
   endclass

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   logic [tgc_pkg::KIND_W-1:0]      req_kind         = tgc_pkg::KIND_PRESS;
   logic [CB-1:0]                   req_pos_x        = '0;
   logic [CB-1:0]                   req_pos_y        = '0;
   logic [tgc_pkg::FINGER_W-1:0]    req_finger_count = '0;
   logic                            req_media_busy   = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   logic [tgc_pkg::ACTION_W-1:0]    rsp_action;
   logic                            rsp_active_page_out;
   logic                            csr_valid        = 1'b0;
   logic                            csr_ready;
   logic [tgc_pkg::CSR_IDX_W-1:0]   csr_index        = tgc_pkg::CSR_TAP_SLOP;
   logic [tgc_pkg::CFG_W-1:0]       csr_wdata        = '0;

   gesture_scoreboard sb = new();
   int  idle_pct   = 0;
   bit  quiet      = 1'b0;
   int  stall_left = 0;

   touch_gesture_classifier #(.COORD_BITS(CB)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_finger_count    (req_finger_count),
      .req_media_busy      (req_media_busy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_active_page_out (rsp_active_page_out),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #1 clock = ~clock;

   // Result side back-pressure comes in random bursts.
   always @(negedge clock) begin
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < idle_pct)
         stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_action, rsp_active_page_out);
   end

   function automatic int clip(int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic logic [tgc_pkg::FINGER_W-1:0] pick_fingers();
      return ($urandom_range(0, 99) < 90) ? tgc_pkg::FINGER_W'(1)
                                          : tgc_pkg::FINGER_W'($urandom_range(0, 7));
   endfunction

   task automatic send_event(logic [tgc_pkg::KIND_W-1:0] kind, int x, int y,
                             logic [tgc_pkg::FINGER_W-1:0] fingers, logic media);
      int gap;
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_kind         = kind;
      req_pos_x        = x[CB-1:0];
      req_pos_y        = y[CB-1:0];
      req_finger_count = fingers;
      req_media_busy   = media;
      do @(posedge clock); while (req_stall);
      sb.note_event(kind, x[CB-1:0], y[CB-1:0], fingers, media);
   endtask

   // Waits until every outstanding event has produced its result.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [tgc_pkg::CSR_IDX_W-1:0] index, int data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data[tgc_pkg::CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data[tgc_pkg::CFG_W-1:0]);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic directed_events();
      send_event(tgc_pkg::KIND_RELEASE, 0, 0, 3'd1, 1'b0);        // release with no press
      send_event(tgc_pkg::KIND_MOVE, 10, 10, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_LONG, 10, 10, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_LOST, 10, 10, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);      // tap on the gauge page
      send_event(tgc_pkg::KIND_RELEASE, 503, 502, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, COORD_MAX, 0, 3'd0, 1'b0);  // full-width left swipe
      send_event(tgc_pkg::KIND_MOVE, 0, 0, 3'd0, 1'b0);
      send_event(tgc_pkg::KIND_RELEASE, 0, 5, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);      // tap on the second page
      send_event(tgc_pkg::KIND_RELEASE, 502, 501, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);      // left swipe, wrong way
      send_event(tgc_pkg::KIND_RELEASE, 400, 500, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 0, COORD_MAX, 3'd1, 1'b0);  // full-width right swipe
      send_event(tgc_pkg::KIND_RELEASE, COORD_MAX, COORD_MAX, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_RELEASE, 500, 400, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_RELEASE, 500, 600, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);      // hold fires once only
      send_event(tgc_pkg::KIND_LONG, 501, 500, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_LONG, 501, 500, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_RELEASE, 501, 500, 3'd1, 1'b0);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd1, 1'b0);      // two-finger hold, busy media
      send_event(tgc_pkg::KIND_LONG, 600, 500, 3'd7, 1'b0);
      send_event(tgc_pkg::KIND_RELEASE, 500, 400, 3'd1, 1'b1);
      send_event(tgc_pkg::KIND_PRESS, 500, 500, 3'd2, 1'b1);
      send_event(tgc_pkg::KIND_LOST, 400, 500, 3'd1, 1'b0);
      send_event(KIND_UNUSED_FIRST, COORD_MAX, COORD_MAX, 3'd7, 1'b1); // unknown kinds
      send_event(KIND_UNUSED_LAST, 0, 0, 3'd2, 1'b0);
   endtask

   task automatic run_gesture();
      int mx;
      int my;
      int dx;
      int dy;
      int sx;
      int sy;
      int moves;
      int slop;
      int smin;
      slop = int'(sb.tap_slop);
      smin = int'(sb.swipe_min);
      case ($urandom_range(0, 3))
         0: begin
            mx = $urandom_range(0, clip(slop + 2));
            my = $urandom_range(0, clip(slop + 2));
         end
         1: begin
            mx = $urandom_range(clip(smin - 4), COORD_MAX);
            my = $urandom_range(0, clip(mx * 4 / 5 + 4));
         end
         2: begin
            my = $urandom_range(clip(smin - 4), COORD_MAX);
            mx = $urandom_range(0, clip(my * 4 / 5 + 4));
         end
         default: begin
            mx = $urandom_range(0, COORD_MAX);
            my = $urandom_range(0, COORD_MAX);
         end
      endcase
      dx = $urandom_range(0, 1) ? -mx : mx;
      dy = $urandom_range(0, 1) ? -my : my;
      sx = (dx < 0) ? $urandom_range(-dx, COORD_MAX) : $urandom_range(0, COORD_MAX - dx);
      sy = (dy < 0) ? $urandom_range(-dy, COORD_MAX) : $urandom_range(0, COORD_MAX - dy);
      send_event(tgc_pkg::KIND_PRESS, sx, sy, pick_fingers(), 1'($urandom_range(0, 1)));
      moves = $urandom_range(0, 3);
      for (int k = 1; k <= moves; k++)
         send_event(tgc_pkg::KIND_MOVE,
                    clip(sx + dx * k / (moves + 1) + int'($urandom_range(0, 8)) - 4),
                    clip(sy + dy * k / (moves + 1) + int'($urandom_range(0, 8)) - 4),
                    pick_fingers(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 15)
         send_event(tgc_pkg::KIND_LONG, clip(sx + dx / 2), clip(sy + dy / 2),
                    pick_fingers(), 1'b0);
      send_event(($urandom_range(0, 99) < 85) ? tgc_pkg::KIND_RELEASE : tgc_pkg::KIND_LOST,
                 sx + dx, sy + dy, pick_fingers(), $urandom_range(0, 99) < 15);
   endtask

   task automatic run_phase(int tap, int swipe, int events);
      drain();
      write_csr(tgc_pkg::CSR_TAP_SLOP, tap);
      write_csr(tgc_pkg::CSR_SWIPE_MIN, swipe);
      for (int n = 0; n < events; n++) begin
         // Change the gap rate now and then so busy and quiet stretches alternate.
         if ($urandom_range(0, 99) < 10) idle_pct = $urandom_range(0, 2) * 25;
         if ($urandom_range(0, 99) < 12)
            send_event(tgc_pkg::KIND_W'($urandom_range(0, 7)), $urandom_range(0, COORD_MAX),
                       $urandom_range(0, COORD_MAX), tgc_pkg::FINGER_W'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
         else
            run_gesture();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_pct = 25;
      directed_events();
      run_phase(0, 0, 31);
      run_phase(COORD_MAX, COORD_MAX, 31);
      run_phase(0, COORD_MAX, 31);
      run_phase(COORD_MAX, 0, 31);
      run_phase($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 31);
      run_phase($urandom_range(4, 30), $urandom_range(30, 200), 31);
      drain();
      quiet = 1'b1;
      run_phase(int'(tgc_pkg::TAP_SLOP_RESET), int'(tgc_pkg::SWIPE_MIN_RESET), 31);
      drain();
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tgc_pkg.sv
rtl/tgc_csr.sv
rtl/tgc_in_reg.sv
rtl/tgc_engine.sv
rtl/touch_gesture_classifier.sv
rtl/tgc_checker.sv
tb/tb_top.sv
